[hdl/mas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_pkg
// Shared widths, codes and types of the matrix add/subtract/multiply engine.
// ----------------------------------------------------------------------------
package mas_pkg;

   // element and field widths
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 3;
   localparam int MODE_W     = 2;
   localparam int DIM_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // load targets
   localparam logic TGT_A = 1'b0;
   localparam logic TGT_B = 1'b1;

   // mode codes, the unused code behaves as multiply
   localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MUL  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM  = 1'b1;

   // register reset values
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_ADD;
   localparam logic [DIM_W-1:0]  DIM_RESET  = 4'd8;

   // configuration seen by the engine
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DIM_W-1:0]  dim;
   } cfg_type;

endpackage

[hdl/mas_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_if
// Valid/ready channels of the engine: request beats in, response beats out.
// ----------------------------------------------------------------------------
interface mas_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic                        target_matrix;
   logic [mas_pkg::IDX_W-1:0]   row_index;
   logic [mas_pkg::IDX_W-1:0]   col_index;
   logic signed [mas_pkg::DATA_W-1:0] element_value;

   modport source (output valid, operation, target_matrix, row_index, col_index,
                   element_value, input ready);
   modport sink   (input valid, operation, target_matrix, row_index, col_index,
                   element_value, output ready);
endinterface

interface mas_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mas_pkg::DATA_W-1:0] result_value;
   logic                              out_of_range;

   modport source (output valid, result_value, out_of_range, input ready);
   modport sink   (input valid, result_value, out_of_range, output ready);
endinterface

[hdl/mas_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_store
// Element memories for matrix A and B: one write port shared by both,
// one registered read port on each.
// ----------------------------------------------------------------------------
module mas_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        wr_sel,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [mas_pkg::DATA_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]           rd_addr_a,
   input  logic [ADDR_W-1:0]           rd_addr_b,
   output logic [mas_pkg::DATA_W-1:0]  rd_data_a,
   output logic [mas_pkg::DATA_W-1:0]  rd_data_b
);

   logic [mas_pkg::DATA_W-1:0] mem_a [DEPTH];
   logic [mas_pkg::DATA_W-1:0] mem_b [DEPTH];
   logic [mas_pkg::DATA_W-1:0] rd_a_ff;
   logic [mas_pkg::DATA_W-1:0] rd_b_ff;

   // matrix a
   always_ff @(posedge clock) begin
      if (wr_en && wr_sel == mas_pkg::TGT_A) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   // matrix b
   always_ff @(posedge clock) begin
      if (wr_en && wr_sel == mas_pkg::TGT_B) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hdl/mas_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_engine
// Request sequencer, multiply-accumulate datapath and response register.
// Drives the element memories and walks the dot product one term a cycle.
// ----------------------------------------------------------------------------
module mas_engine #(
   parameter int MAX_DIM = 8,
   parameter int ADDR_W  = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mas_pkg::cfg_type            cfg,
   mas_req_if.sink                     req,
   mas_rsp_if.source                   rsp,
   output logic                        wr_en,
   output logic                        wr_sel,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [mas_pkg::DATA_W-1:0]  wr_data,
   output logic [ADDR_W-1:0]           rd_addr_a,
   output logic [ADDR_W-1:0]           rd_addr_b,
   input  logic [mas_pkg::DATA_W-1:0]  rd_data_a,
   input  logic [mas_pkg::DATA_W-1:0]  rd_data_b
);

   localparam int DW = mas_pkg::DATA_W;
   localparam int NW = mas_pkg::DIM_W;
   localparam int IW = mas_pkg::IDX_W;

   // largest usable dimension in the width of the dimension register
   localparam logic [NW-1:0] DIM_CAP = (MAX_DIM > 15) ? {NW{1'b1}} : NW'(MAX_DIM);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ELEM  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] col_ff, col_in;
   logic [NW-1:0] k_ff, k_in;
   logic          err_ff, err_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          prod_vld_ff;
   logic [DW-1:0] prod_ff;
   logic          rsp_vld_ff, rsp_vld_in;
   logic [DW-1:0] rsp_val_ff, rsp_val_in;
   logic          rsp_err_ff, rsp_err_in;

   logic [NW-1:0]   dim_act;
   logic [NW-1:0]   last_k;
   logic            is_mul;
   logic            is_sub;
   logic            accept;
   logic            query_acc;
   logic            in_range;
   logic            issue;
   logic            out_free;
   logic [IW-1:0]   cur_row;
   logic [IW-1:0]   cur_col;
   logic [NW-1:0]   cur_k;
   logic [NW-1:0]   a_col;
   logic [NW-1:0]   b_row;
   logic [2*DW-1:0] prod_full;

   // effective dimension and mode decode
   assign dim_act = (cfg.dim > DIM_CAP) ? DIM_CAP : cfg.dim;
   assign last_k  = dim_act - NW'(1);
   assign is_mul  = (cfg.mode == mas_pkg::MODE_MUL) || (cfg.mode == mas_pkg::MODE_RSVD);
   assign is_sub  = (cfg.mode == mas_pkg::MODE_SUB);

   // request handshake
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign query_acc = accept && (req.operation == mas_pkg::OP_QUERY);
   assign in_range  = ({1'b0, req.row_index} < dim_act) && ({1'b0, req.col_index} < dim_act);

   // load write port, loads outside the store are dropped
   assign wr_en   = accept && (req.operation == mas_pkg::OP_LOAD) &&
                    (32'(req.row_index) < 32'(MAX_DIM)) &&
                    (32'(req.col_index) < 32'(MAX_DIM));
   assign wr_sel  = req.target_matrix;
   assign wr_addr = ADDR_W'(32'(req.row_index) * 32'(MAX_DIM) + 32'(req.col_index));
   assign wr_data = DW'(req.element_value);

   // read address: straight from the beat on accept, then from the held query
   assign cur_row = (state_ff == S_IDLE) ? req.row_index : row_ff;
   assign cur_col = (state_ff == S_IDLE) ? req.col_index : col_ff;
   assign cur_k   = (state_ff == S_IDLE) ? '0 : k_ff;
   assign a_col   = is_mul ? cur_k : {1'b0, cur_col};
   assign b_row   = is_mul ? cur_k : {1'b0, cur_row};

   assign rd_addr_a = ADDR_W'(32'(cur_row) * 32'(MAX_DIM) + 32'(a_col));
   assign rd_addr_b = ADDR_W'(32'(b_row) * 32'(MAX_DIM) + 32'(cur_col));

   // a dot-product term is fetched on the accepting edge and in each multiply cycle
   assign issue = (query_acc && in_range && is_mul) || (state_ff == S_MUL);

   // low word of the term product
   assign prod_full = rd_data_a * rd_data_b;

   assign out_free = !rsp_vld_ff || rsp.ready;

   // sequencer and accumulator
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      k_in     = k_ff;
      err_in   = err_ff;
      acc_in   = acc_ff;
      if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (query_acc) begin
               row_in = req.row_index;
               col_in = req.col_index;
               k_in   = NW'(1);
               err_in = !in_range;
               acc_in = '0;
               if (!in_range) begin
                  state_in = S_DONE;
               end else if (!is_mul) begin
                  state_in = S_ELEM;
               end else if (dim_act == NW'(1)) begin
                  state_in = S_DRAIN;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_ELEM: begin
            acc_in   = is_sub ? (rd_data_a - rd_data_b) : (rd_data_a + rd_data_b);
            state_in = S_DONE;
         end
         S_MUL: begin
            k_in = k_ff + NW'(1);
            if (k_ff == last_k) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_vld_in = issue;

   // response register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_val_in = rsp_val_ff;
      rsp_err_in = rsp_err_ff;
      if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_vld_in = 1'b1;
         rsp_val_in = acc_ff;
         rsp_err_in = err_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= rd_vld_ff;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      k_ff       <= k_in;
      err_ff     <= err_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_full[DW-1:0];
      rsp_val_ff <= rsp_val_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.result_value = $signed(rsp_val_ff);
   assign rsp.out_of_range = rsp_err_ff;

endmodule

[hdl/matrix_add_sub_multiply.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply
// Square integer matrix engine: element loads into A and B, and queries of
// one element of A+B, A-B or A*B, wrapping modulo 2^32.
// ----------------------------------------------------------------------------
// A load is written into its memory on the accepting edge and the next
// beat can follow at once. An element-wise query passes through the accept
// with memory read, the add or subtract and the response register. A
// multiply query reads the d terms of the dot product, d being the dimension
// in use capped at MAX_DIM, one from each memory per cycle; each term is
// multiplied in the next and accumulated in the one after, so the
// single read port of each memory sets the rate. The query passes through
// the accept, the further term reads, the drain of the read and multiply
// stages and the response register. An out-of-range query goes from the
// accept straight to the response register. A query whose response register
// is still occupied waits in its last cycle until that response is taken.
// The response register lets a new request be accepted while the previous
// response is still waiting. Loads only happen while the sequencer is idle,
// so no read ever overlaps a write to the same element. Memory contents are
// undefined until loaded; there is no clearing pass.
module matrix_add_sub_multiply #(
   parameter int MAX_DIM = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   mas_req_if.sink                            req_chan,
   mas_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [mas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mas_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [mas_pkg::MODE_W-1:0] mode_ff;
   logic [mas_pkg::DIM_W-1:0]  dim_ff;
   mas_pkg::cfg_type           cfg;

   logic                       wr_en;
   logic                       wr_sel;
   logic [ADDR_W-1:0]          wr_addr;
   logic [mas_pkg::DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0]          rd_addr_a;
   logic [ADDR_W-1:0]          rd_addr_b;
   logic [mas_pkg::DATA_W-1:0] rd_data_a;
   logic [mas_pkg::DATA_W-1:0] rd_data_b;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mas_pkg::MODE_RESET;
         dim_ff  <= mas_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mas_pkg::CSR_MODE: mode_ff <= csr_data[mas_pkg::MODE_W-1:0];
            mas_pkg::CSR_DIM:  dim_ff  <= csr_data[mas_pkg::DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode = mode_ff;
   assign cfg.dim  = dim_ff;

   // sequencer and datapath
   mas_engine #(
      .MAX_DIM (MAX_DIM),
      .ADDR_W  (ADDR_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .wr_en     (wr_en),
      .wr_sel    (wr_sel),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // element memories
   mas_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_sel    (wr_sel),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // no response is pending right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

   // a query keeps the request side closed on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.operation == mas_pkg::OP_QUERY)
      |=> !req_chan.ready)
      else $error("request accepted while a query is in flight");

   // an out-of-range response carries zero
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_of_range) |-> (rsp_chan.result_value == '0))
      else $error("out-of-range response with nonzero value");

   // a load never produces a response beat by itself
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.operation == mas_pkg::OP_LOAD &&
       !rsp_chan.valid) |=> !rsp_chan.valid)
      else $error("response appeared after a load");

endmodule
